FILE: rtl/humidity_pressure_temp_compensation_assert.svh
// assertion macros for the compensation block
// expects clk and arst_n in the scope of use
`ifndef HUMIDITY_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define HUMIDITY_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// same-cycle implication
`define HPTC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define HPTC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: rtl/hptc_pkg.sv
// types, register codes and divider step for the compensation block
// no dependencies
`default_nettype none

package hptc_pkg;

	localparam logic [2:0] CFG_TEMP       = 3'd0;
	localparam logic [2:0] CFG_PRESS_LOW  = 3'd1;
	localparam logic [2:0] CFG_PRESS_HIGH = 3'd2;
	localparam logic [2:0] CFG_MIXED      = 3'd3;
	localparam logic [2:0] CFG_HUMID      = 3'd4;

	localparam int DIV_BITS = 64;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
		logic [15:0] raw_humidity;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic [31:0]        pressure_q24_8;
		logic [16:0]        humidity_q22_10;
		logic               pressure_invalid;
	} out_item_t;

	typedef struct packed {
		logic [63:0]        rem;
		logic [63:0]        quo;
		logic [63:0]        den;
		logic               neg;
		logic               zero;
		logic signed [31:0] temp;
		logic [16:0]        hum;
	} div_item_t;

	// one restoring step: quotient bits shift in where numerator bits shift out
	function automatic div_item_t div_step(input div_item_t a);
		div_item_t b;
		logic [65:0] trial;
		b = a;
		trial = {1'b0, a.rem, a.quo[63]} - {2'b00, a.den};
		if (trial[65]) begin
			b.rem = {a.rem[62:0], a.quo[63]};
			b.quo = {a.quo[62:0], 1'b0};
		end else begin
			b.rem = trial[63:0];
			b.quo = {a.quo[62:0], 1'b1};
		end
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/hptc_div.sv
// pipelined 64-bit unsigned divider, one quotient bit per stage
// depends on hptc_pkg
`default_nettype none

module hptc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  hptc_pkg::div_item_t in_item,
	output logic                out_valid,
	output hptc_pkg::div_item_t out_item
);
	import hptc_pkg::*;

	logic [DIV_BITS-1:0] vld_q;
	div_item_t           stage_q [DIV_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DIV_BITS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q[0] <= div_step(in_item);
			for (int i = 1; i < DIV_BITS; i++) begin
				stage_q[i] <= div_step(stage_q[i-1]);
			end
		end
	end

	assign out_valid = vld_q[DIV_BITS-1];
	assign out_item  = stage_q[DIV_BITS-1];

endmodule

`default_nettype wire

FILE: rtl/humidity_pressure_temp_compensation.sv
// throughput: one beat per cycle unless stalled; 11 arithmetic stages, a 64-stage
// divider (one quotient bit per stage) and 4 pressure finishing stages
// the whole pipe holds while a result beat is stalled
// reset clears valid bits and coefficient registers, no clearing pass
`default_nettype none
`include "humidity_pressure_temp_compensation_assert.svh"

module humidity_pressure_temp_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  hptc_pkg::in_item_t sample,
	output logic               result_valid,
	input  logic               result_stall,
	output hptc_pkg::out_item_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import hptc_pkg::*;

	localparam logic signed [31:0] HUM_MAX = 32'sd419430400;

	logic [47:0] temp_coeffs_q;
	logic [63:0] press_low_q;
	logic [63:0] press_high_q;
	logic [47:0] mixed_coeffs_q;
	logic [31:0] humid_coeffs_q;

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
	logic [7:0]         h1, h3;
	logic signed [11:0] h4, h5;
	logic signed [7:0]  h6;

	logic adv;
	logic [10:0] vld_q;
	logic [3:0]  post_vld_q;

	logic signed [31:0] e1, td, tmul, xpre, rr;
	logic [20:0]        pn;
	logic [16:0]        hum_c;
	logic signed [65:0] vsq_full;

	// stage registers
	logic signed [31:0] a1m_s1, dd_s1;
	logic signed [31:0] a1_s2, a2m_s2;
	logic signed [31:0] tfine_s3;
	logic signed [32:0] v1_s4;
	logic signed [31:0] hv_s4;
	logic signed [63:0] vsq_s5;
	logic signed [48:0] v1p5_s5, v1p2_s5, v1p5_s6, v1p2_s6;
	logic signed [31:0] ha_s5, hb_s5, hc_s5;
	logic signed [63:0] v2a_s6, v1a_s6, v2_s7, v1b_s7, v1c_s8, p0_s8, v1f_s9, num_s9;
	logic signed [31:0] x_s6, x_s7, x_s8, ym_s6, y2_s7, y3m_s8;
	logic signed [31:0] r_s9, r_s10, r_s11, r2sq_s10, t_s11;
	logic [63:0]        an_s10, ad_s10, an_s11, ad_s11;
	logic               neg_s10, neg_s11, zero_s10, zero_s11;
	logic [19:0] rawp_s1, rawp_s2, rawp_s3, rawp_s4, rawp_s5, rawp_s6, rawp_s7;
	logic [15:0] rawh_s1, rawh_s2, rawh_s3, rawh_s4, rawh_s5;
	logic signed [31:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;
	logic signed [31:0] temp_s10, temp_s11;

	div_item_t div_in, div_out;
	logic      div_out_valid;

	logic signed [63:0] pq, psh, sum, res;
	logic signed [63:0] p_s76, p_s77, p_s78, c2m_s76, c2_s77, c2_s78, c1m_s78;
	logic signed [63:0] pssq_s77;
	logic [63:0]        pp0_s76;
	logic [31:0]        pp1_s76;
	logic signed [31:0] temp_s76, temp_s77, temp_s78;
	logic [16:0]        hum_s76, hum_s77, hum_s78;
	logic               zero_s76, zero_s77, zero_s78;
	out_item_t          result_s79;

	// coefficient fields
	assign t1 = temp_coeffs_q[15:0];
	assign t2 = temp_coeffs_q[31:16];
	assign t3 = temp_coeffs_q[47:32];
	assign p1 = press_low_q[15:0];
	assign p2 = press_low_q[31:16];
	assign p3 = press_low_q[47:32];
	assign p4 = press_low_q[63:48];
	assign p5 = press_high_q[15:0];
	assign p6 = press_high_q[31:16];
	assign p7 = press_high_q[47:32];
	assign p8 = press_high_q[63:48];
	assign p9 = mixed_coeffs_q[15:0];
	assign h1 = mixed_coeffs_q[23:16];
	assign h2 = mixed_coeffs_q[39:24];
	assign h3 = mixed_coeffs_q[47:40];
	assign h4 = humid_coeffs_q[11:0];
	assign h5 = humid_coeffs_q[23:12];
	assign h6 = humid_coeffs_q[31:24];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q  <= '0;
			press_low_q    <= '0;
			press_high_q   <= '0;
			mixed_coeffs_q <= '0;
			humid_coeffs_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TEMP:       temp_coeffs_q  <= cfg_data[47:0];
				CFG_PRESS_LOW:  press_low_q    <= cfg_data;
				CFG_PRESS_HIGH: press_high_q   <= cfg_data;
				CFG_MIXED:      mixed_coeffs_q <= cfg_data[47:0];
				CFG_HUMID:      humid_coeffs_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign result_valid = post_vld_q[3];
	assign result       = result_s79;
	assign adv          = !(result_valid && result_stall);
	assign sample_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			post_vld_q <= '0;
		end else if (adv) begin
			vld_q      <= {vld_q[9:0], sample_valid};
			post_vld_q <= {post_vld_q[2:0], div_out_valid};
		end
	end

	always_comb begin
		e1 = $signed({15'd0, sample.raw_temperature[19:3]}) - $signed({15'd0, t1, 1'b0});
		td = $signed({16'd0, sample.raw_temperature[19:4]} - {16'd0, t1});
		tmul = tfine_s3 * 32'sd5 + 32'sd128;
		vsq_full = v1_s4 * v1_s4;
		xpre = $signed({2'd0, rawh_s5, 14'd0}) - $signed({h4, 20'd0}) - ha_s5 + 32'sd16384;
		pn = 21'd1048576 - {1'b0, rawp_s7};
		rr = r_s11 - (t_s11 >>> 4);
		if (rr < 0) begin
			rr = '0;
		end else if (rr > HUM_MAX) begin
			rr = HUM_MAX;
		end
		hum_c = rr[28:12];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// temperature
			a1m_s1  <= e1 * 32'(t2);
			dd_s1   <= td * td;
			rawp_s1 <= sample.raw_pressure;
			rawh_s1 <= sample.raw_humidity;

			a1_s2   <= a1m_s1 >>> 11;
			a2m_s2  <= (dd_s1 >>> 12) * 32'(t3);
			rawp_s2 <= rawp_s1;
			rawh_s2 <= rawh_s1;

			tfine_s3 <= a1_s2 + (a2m_s2 >>> 14);
			rawp_s3  <= rawp_s2;
			rawh_s3  <= rawh_s2;

			temp_s4 <= tmul >>> 8;
			v1_s4   <= 33'(tfine_s3) - 33'sd128000;
			hv_s4   <= tfine_s3 - 32'sd76800;
			rawp_s4 <= rawp_s3;
			rawh_s4 <= rawh_s3;

			// pressure and humidity products
			vsq_s5  <= vsq_full[63:0];
			v1p5_s5 <= 49'(v1_s4) * 49'(p5);
			v1p2_s5 <= 49'(v1_s4) * 49'(p2);
			ha_s5   <= hv_s4 * 32'(h5);
			hb_s5   <= hv_s4 * 32'(h6);
			hc_s5   <= hv_s4 * 32'($signed({1'b0, h3}));
			temp_s5 <= temp_s4;
			rawp_s5 <= rawp_s4;
			rawh_s5 <= rawh_s4;

			v2a_s6  <= vsq_s5 * 64'(p6);
			v1a_s6  <= vsq_s5 * 64'(p3);
			v1p5_s6 <= v1p5_s5;
			v1p2_s6 <= v1p2_s5;
			x_s6    <= xpre >>> 15;
			ym_s6   <= (hb_s5 >>> 10) * ((hc_s5 >>> 11) + 32'sd32768);
			temp_s6 <= temp_s5;
			rawp_s6 <= rawp_s5;

			v2_s7   <= v2a_s6 + (64'(v1p5_s6) <<< 17) + (64'(p4) <<< 35);
			v1b_s7  <= (v1a_s6 >>> 8) + (64'(v1p2_s6) <<< 12);
			y2_s7   <= (ym_s6 >>> 10) + 32'sd2097152;
			x_s7    <= x_s6;
			temp_s7 <= temp_s6;
			rawp_s7 <= rawp_s6;

			v1c_s8  <= (64'sh0000_8000_0000_0000 + v1b_s7) * 64'($signed({1'b0, p1}));
			p0_s8   <= $signed({12'd0, pn, 31'd0}) - v2_s7;
			y3m_s8  <= y2_s7 * 32'(h2) + 32'sd8192;
			x_s8    <= x_s7;
			temp_s8 <= temp_s7;

			v1f_s9  <= v1c_s8 >>> 33;
			num_s9  <= p0_s8 * 64'sd3125;
			r_s9    <= x_s8 * (y3m_s8 >>> 14);
			temp_s9 <= temp_s8;

			zero_s10 <= (v1f_s9 == 64'sd0);
			neg_s10  <= num_s9[63] ^ v1f_s9[63];
			an_s10   <= num_s9[63] ? -num_s9 : num_s9;
			ad_s10   <= v1f_s9[63] ? -v1f_s9 : v1f_s9;
			r2sq_s10 <= (r_s9 >>> 15) * (r_s9 >>> 15);
			r_s10    <= r_s9;
			temp_s10 <= temp_s9;

			t_s11    <= (r2sq_s10 >>> 7) * 32'($signed({1'b0, h1}));
			r_s11    <= r_s10;
			an_s11   <= an_s10;
			ad_s11   <= ad_s10;
			neg_s11  <= neg_s10;
			zero_s11 <= zero_s10;
			temp_s11 <= temp_s10;

			// pressure finishing after the divider
			p_s76    <= pq;
			pp0_s76  <= 64'(psh[31:0]) * 64'(psh[31:0]);
			pp1_s76  <= psh[31:0] * psh[63:32];
			c2m_s76  <= pq * 64'(p8);
			temp_s76 <= div_out.temp;
			hum_s76  <= div_out.hum;
			zero_s76 <= div_out.zero;

			pssq_s77 <= $signed(pp0_s76 + {pp1_s76[30:0], 1'b0, 32'd0});
			c2_s77   <= c2m_s76 >>> 19;
			p_s77    <= p_s76;
			temp_s77 <= temp_s76;
			hum_s77  <= hum_s76;
			zero_s77 <= zero_s76;

			c1m_s78  <= 64'(p9) * pssq_s77;
			c2_s78   <= c2_s77;
			p_s78    <= p_s77;
			temp_s78 <= temp_s77;
			hum_s78  <= hum_s77;
			zero_s78 <= zero_s77;

			result_s79.temperature_centi <= temp_s78;
			result_s79.pressure_q24_8    <= zero_s78 ? 32'd0 : res[31:0];
			result_s79.humidity_q22_10   <= hum_s78;
			result_s79.pressure_invalid  <= zero_s78;
		end
	end

	always_comb begin
		div_in.rem  = '0;
		div_in.quo  = an_s11;
		div_in.den  = ad_s11;
		div_in.neg  = neg_s11;
		div_in.zero = zero_s11;
		div_in.temp = temp_s11;
		div_in.hum  = hum_c;
	end

	hptc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_q[10]),
		.in_item   (div_in),
		.out_valid (div_out_valid),
		.out_item  (div_out)
	);

	always_comb begin
		pq  = div_out.neg ? -$signed(div_out.quo) : $signed(div_out.quo);
		psh = pq >>> 13;
		sum = p_s78 + (c1m_s78 >>> 25) + c2_s78;
		res = (sum >>> 8) + (64'(p7) <<< 4);
	end

	`HPTC_ASSERT_IMP(a_invalid_zero, result_valid && result.pressure_invalid,
		result.pressure_q24_8 == 32'd0, "invalid pressure beat carries nonzero value")
	`HPTC_ASSERT_IMP(a_hum_range, result_valid, result.humidity_q22_10 <= 17'd102400,
		"humidity above full scale")
	`HPTC_ASSERT_IMP(a_stall_src, !result_valid, !sample_stall,
		"sample stalled with empty output")
	`HPTC_ASSERT_NXT(a_drain, post_vld_q[2] && !sample_stall, result_valid,
		"finished beat did not reach output")

endmodule

`default_nettype wire
